FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every cycle out of reset
`define ASSERT_ALWAYS(name, clk_s, rst_s, cond) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/wsfp_pkg.sv
package wsfp_pkg;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef enum logic {
    CMD_PAYLOAD = 1'b0,
    CMD_HEADER  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        fin;
    logic [3:0]  op;
    logic [63:0] length;
    logic [7:0]  data;
    logic [7:0]  key_byte;
    logic        eof;
  } cmd_t;

  localparam logic [7:0] FIN_MASK  = 8'h80;
  localparam logic [7:0] OP_MASK   = 8'h0F;
  localparam logic [7:0] LEN_MASK  = 8'h7F;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

endpackage

FILE: rtl/wsfp_queue.sv
`include "assert_macros.svh"

module wsfp_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wsfp_pkg::cmd_t  din,
  output logic            full,
  input  logic            pop,
  output wsfp_pkg::cmd_t  dout,
  output logic            empty
);
  import wsfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))

endmodule

FILE: rtl/wsfp_front.sv
`include "assert_macros.svh"

module wsfp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      stream_byte,
  input  logic            push,
  output logic            full,
  output wsfp_pkg::cmd_t  cmd,
  output logic            cmd_push,
  input  logic            cmd_full
);
  import wsfp_pkg::*;

  phase_t      phase, phase_next;
  logic        fin, fin_next;
  logic [3:0]  op, op_next;
  logic        mask_en, mask_en_next;
  logic [3:0]  ext_left, ext_left_next;
  logic [63:0] len, len_next;
  logic [31:0] key, key_next;
  logic [2:0]  key_left, key_left_next;
  logic [63:0] rem, rem_next;
  logic [1:0]  key_pos, key_pos_next;

  logic        accept;
  logic        len_done;
  logic        hdr_done;
  logic [6:0]  code;
  logic [31:0] key_shift;
  logic        hdr_eof;

  assign full      = cmd_full;
  assign accept    = push && !cmd_full;
  assign code      = 7'(stream_byte & LEN_MASK);
  assign key_shift = key >> {~key_pos, 3'b000};

  always_comb begin
    phase_next    = phase;
    fin_next      = fin;
    op_next       = op;
    mask_en_next  = mask_en;
    ext_left_next = ext_left;
    len_next      = len;
    key_next      = key;
    key_left_next = key_left;
    rem_next      = rem;
    key_pos_next  = key_pos;
    len_done      = 1'b0;
    hdr_done      = 1'b0;
    hdr_eof       = 1'b0;
    cmd_push      = 1'b0;
    cmd.kind      = CMD_PAYLOAD;
    cmd.fin       = fin;
    cmd.op        = op;
    cmd.length    = len;
    cmd.data      = stream_byte;
    cmd.key_byte  = 8'd0;
    cmd.eof       = 1'b0;

    if (accept) begin
      case (phase)
        PH_HDR0: begin
          fin_next   = |(stream_byte & FIN_MASK);
          op_next    = 4'(stream_byte & OP_MASK);
          phase_next = PH_HDR1;
        end
        PH_HDR1: begin
          mask_en_next = |(stream_byte & FIN_MASK);
          len_next     = 64'd0;
          if (code == LEN_EXT16) begin
            ext_left_next = 4'd2;
            phase_next    = PH_EXTLEN;
          end else if (code == LEN_EXT64) begin
            ext_left_next = 4'd8;
            phase_next    = PH_EXTLEN;
          end else begin
            len_next = 64'(code);
            len_done = 1'b1;
          end
        end
        PH_EXTLEN: begin
          len_next      = {len[55:0], stream_byte};
          ext_left_next = ext_left - 4'd1;
          len_done      = (ext_left_next == 4'd0);
        end
        PH_KEY: begin
          key_next      = {key[23:0], stream_byte};
          key_left_next = key_left - 3'd1;
          hdr_done      = (key_left_next == 3'd0);
        end
        PH_PAYLOAD: begin
          cmd.kind     = CMD_PAYLOAD;
          cmd.key_byte = mask_en ? key_shift[7:0] : 8'd0;
          key_pos_next = key_pos + 2'd1;
          rem_next     = rem - 64'd1;
          cmd.eof      = (rem_next == 64'd0);
          cmd_push     = 1'b1;
          if (rem_next == 64'd0) begin
            phase_next = PH_HDR0;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase

      if (len_done) begin
        if (mask_en_next) begin
          key_next      = 32'd0;
          key_left_next = 3'd4;
          phase_next    = PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        hdr_eof    = (len_next == 64'd0);
        cmd.kind   = CMD_HEADER;
        cmd.length = len_next;
        cmd.data   = 8'd0;
        cmd.eof    = hdr_eof;
        cmd_push   = 1'b1;
        if (hdr_eof) begin
          phase_next = PH_HDR0;
        end else begin
          rem_next     = len_next;
          key_pos_next = 2'd0;
          phase_next   = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HDR0;
      fin      <= 1'b0;
      op       <= 4'd0;
      mask_en  <= 1'b0;
      ext_left <= 4'd0;
      len      <= 64'd0;
      key      <= 32'd0;
      key_left <= 3'd0;
      rem      <= 64'd0;
      key_pos  <= 2'd0;
    end else begin
      phase    <= phase_next;
      fin      <= fin_next;
      op       <= op_next;
      mask_en  <= mask_en_next;
      ext_left <= ext_left_next;
      len      <= len_next;
      key      <= key_next;
      key_left <= key_left_next;
      rem      <= rem_next;
      key_pos  <= key_pos_next;
    end
  end

  `ASSERT_IMPLIES(a_push_not_full, clk, rst, cmd_push, !cmd_full)
  `ASSERT_IMPLIES(a_payload_rem, clk, rst, phase == PH_PAYLOAD, rem != 64'd0)

endmodule

FILE: rtl/wsfp_back.sv
`include "assert_macros.svh"

module wsfp_back (
  input  logic            clk,
  input  logic            rst,
  input  wsfp_pkg::cmd_t  cmd,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  output logic            empty,
  input  logic            pop,
  output logic            is_header,
  output logic            final_fragment,
  output logic [3:0]      op_code,
  output logic [63:0]     frame_length,
  output logic [7:0]      payload_byte,
  output logic            end_of_frame
);
  import wsfp_pkg::*;

  logic        out_valid;
  logic        take;
  logic        ctx_fin;
  logic [3:0]  ctx_op;
  logic [63:0] ctx_len;

  assign empty   = !out_valid;
  assign take    = !cmd_empty && (!out_valid || pop);
  assign cmd_pop = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // frame context latched from the header item, payload items reuse it
  always_ff @(posedge clk) begin
    if (take) begin
      end_of_frame <= cmd.eof;
      if (cmd.kind == CMD_HEADER) begin
        ctx_fin        <= cmd.fin;
        ctx_op         <= cmd.op;
        ctx_len        <= cmd.length;
        is_header      <= 1'b1;
        final_fragment <= cmd.fin;
        op_code        <= cmd.op;
        frame_length   <= cmd.length;
        payload_byte   <= 8'd0;
      end else begin
        is_header      <= 1'b0;
        final_fragment <= ctx_fin;
        op_code        <= ctx_op;
        frame_length   <= ctx_len;
        payload_byte   <= cmd.data ^ cmd.key_byte;
      end
    end
  end

  `ASSERT_IMPLIES(a_hdr_eof_len, clk, rst, out_valid && is_header && end_of_frame, frame_length == 64'd0)

endmodule

FILE: rtl/websocket_frame_parser.sv
// a result is written into the command queue and then loaded into the output register that drives the output ports
// throughput: one byte per cycle while the command queue is not full, one result per cycle while pop keeps up
// a command queue of QUEUE_DEPTH entries (four by default) and an output register let input and output stall apart
// reset: synchronous rst returns the parser to the first header byte and empties the queue and output register
module websocket_frame_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  stream_byte,
  input  logic        push,
  output logic        full,
  output logic        is_header,
  output logic        final_fragment,
  output logic [3:0]  op_code,
  output logic [63:0] frame_length,
  output logic [7:0]  payload_byte,
  output logic        end_of_frame,
  output logic        empty,
  input  logic        pop
);
  import wsfp_pkg::*;

  cmd_t q_din;
  cmd_t q_dout;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  wsfp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .stream_byte (stream_byte),
    .push        (push),
    .full        (full),
    .cmd         (q_din),
    .cmd_push    (q_push),
    .cmd_full    (q_full)
  );

  wsfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  wsfp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd            (q_dout),
    .cmd_empty      (q_empty),
    .cmd_pop        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .is_header      (is_header),
    .final_fragment (final_fragment),
    .op_code        (op_code),
    .frame_length   (frame_length),
    .payload_byte   (payload_byte),
    .end_of_frame   (end_of_frame)
  );

endmodule
